/* src/sorted_priority_queue_assert.svh */
// Assertion macros used by the checker file.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SPQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("spq assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spq assertion failed");

`endif

/* src/spq_pkg.sv */
package spq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int REQ_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int TOTAL_W     = 5;

   typedef enum logic [REQ_W-1:0] {
      REQ_ENQUEUE = 2'd0,
      REQ_DEQUEUE = 2'd1,
      REQ_STATUS  = 2'd2
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_code_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
   } entry_type;

   // Per-cell control, driven by the top level each cycle.
   typedef struct packed {
      logic enq;         // insert transfer in progress, queue not full
      logic deq;         // remove transfer in progress, queue not empty
      logic valid;       // cell holds a live entry
      logic keep_above;  // neighbour above keeps its entry on insert
   } cell_ctl_type;

endpackage

/* src/spq_req_if.sv */
interface spq_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [spq_pkg::REQ_W-1:0]               req_type;
   logic signed [spq_pkg::DATA_W-1:0]       item_value;
   logic signed [spq_pkg::DATA_W-1:0]       item_priority;

   modport source (output valid, output req_type, output item_value,
                   output item_priority, input ready);
   modport sink   (input valid, input req_type, input item_value,
                   input item_priority, output ready);
endinterface

/* src/spq_rsp_if.sv */
interface spq_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic [spq_pkg::STATUS_W-1:0]            status;
   logic signed [spq_pkg::DATA_W-1:0]       removed_value;
   logic signed [spq_pkg::DATA_W-1:0]       top_value;
   logic signed [spq_pkg::DATA_W-1:0]       top_priority;
   logic [spq_pkg::TOTAL_W-1:0]             entry_total;

   modport source (output valid, output status, output removed_value,
                   output top_value, output top_priority, output entry_total,
                   input ready);
   modport sink   (input valid, input status, input removed_value,
                   input top_value, input top_priority, input entry_total,
                   output ready);
endinterface

/* src/spq_cell.sv */
// One slot of the sorted row; slot 0 is the top of the queue.
module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_ctl_type ctl,
   input  spq_pkg::entry_type    new_entry,
   input  spq_pkg::entry_type    above_entry,
   input  spq_pkg::entry_type    below_entry,
   output spq_pkg::entry_type    entry,
   output logic                  keep
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // Keep on insert when live and not strictly below the new priority.
   assign keep = ctl.valid && !(entry_ff.prio < new_entry.prio);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.enq) begin
         if (!keep) begin
            entry_in = ctl.keep_above ? new_entry : above_entry;
         end
      end else if (ctl.deq) begin
         entry_in = below_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

/* src/sorted_priority_queue.sv */
// Each result is registered from its request transfer.
// Throughput: one request per cycle while the result side takes each result.
// Every cell compares against the new priority and shifts in the same cycle.
// Reset: clears the entry count and the result valid; slot contents stay
// unreset, as only live slots are ever reported.
module sorted_priority_queue (
   input logic        clock,
   input logic        reset,
   spq_req_if.sink    req_chan,
   spq_rsp_if.source  rsp_chan
);

   localparam int DEPTH = spq_pkg::QUEUE_DEPTH;
   localparam int CW    = spq_pkg::CNT_W;

   // Entry count
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   // Result register
   logic                                  rsp_valid_ff;
   logic                                  rsp_valid_in;
   logic [spq_pkg::STATUS_W-1:0]          status_ff;
   logic [spq_pkg::STATUS_W-1:0]          status_in;
   logic signed [spq_pkg::DATA_W-1:0]     removed_ff;
   logic signed [spq_pkg::DATA_W-1:0]     removed_in;
   spq_pkg::entry_type                    top_ff;
   spq_pkg::entry_type                    top_in;
   logic [spq_pkg::TOTAL_W-1:0]           total_ff;
   logic [spq_pkg::TOTAL_W-1:0]           total_in;

   logic                  accept;
   logic                  full;
   logic                  empty;
   logic                  is_enq;
   logic                  is_deq;
   logic                  enq_ok;
   logic                  deq_ok;
   spq_pkg::entry_type    new_entry;

   // Row of cells, padded with a blank entry at each end.
   spq_pkg::entry_type    row_entry [DEPTH+2];
   logic                  row_keep  [DEPTH+1];

   // Accept a request whenever the result register is free or drains now.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      is_enq = 1'b0;
      is_deq = 1'b0;
      unique case (spq_pkg::req_code_type'(req_chan.req_type))
         spq_pkg::REQ_ENQUEUE: is_enq = 1'b1;
         spq_pkg::REQ_DEQUEUE: is_deq = 1'b1;
         default:              ;  // status only, unused code likewise
      endcase
   end

   assign enq_ok = accept && is_enq && !full;
   assign deq_ok = accept && is_deq && !empty;

   assign new_entry.value = req_chan.item_value;
   assign new_entry.prio  = req_chan.item_priority;

   assign row_entry[0]       = '0;
   assign row_entry[DEPTH+1] = '0;
   assign row_keep[0]        = 1'b1;

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      spq_pkg::cell_ctl_type ctl;

      always_comb begin
         ctl.enq        = enq_ok;
         ctl.deq        = deq_ok;
         ctl.valid      = (CW'(k) < count_ff);
         ctl.keep_above = row_keep[k];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .new_entry   (new_entry),
         .above_entry (row_entry[k]),
         .below_entry (row_entry[k+2]),
         .entry       (row_entry[k+1]),
         .keep        (row_keep[k+1])
      );
   end

   // Count: advance on insert, drop on removal, hold otherwise.
   always_comb begin
      count_in = count_ff;
      if (enq_ok) begin
         count_in = count_ff + CW'(1);
      end else if (deq_ok) begin
         count_in = count_ff - CW'(1);
      end
   end

   // Result: work out the post-step top from the cells as they stand now.
   always_comb begin
      status_in  = spq_pkg::ST_OK;
      removed_in = '0;
      top_in     = '0;
      total_in   = spq_pkg::TOTAL_W'(count_in);

      if (accept && is_enq && full) begin
         status_in = spq_pkg::ST_FULL;
      end else if (accept && is_deq && empty) begin
         status_in = spq_pkg::ST_EMPTY;
      end

      if (enq_ok) begin
         // New entry lands on top when the current top does not keep its slot.
         top_in = row_keep[1] ? row_entry[1] : new_entry;
      end else if (deq_ok) begin
         removed_in = row_entry[1].value;
         if (count_ff > CW'(1)) begin
            top_in = row_entry[2];
         end
      end else if (!empty) begin
         top_in = row_entry[1];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result payload only on a request transfer.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status_in;
         removed_ff <= removed_in;
         top_ff     <= top_in;
         total_ff   <= total_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.removed_value = removed_ff;
   assign rsp_chan.top_value     = top_ff.value;
   assign rsp_chan.top_priority  = top_ff.prio;
   assign rsp_chan.entry_total   = total_ff;

endmodule

/* src/spq_checker.sv */
`include "sorted_priority_queue_assert.svh"

module spq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [spq_pkg::STATUS_W-1:0]      rsp_status,
   input logic signed [spq_pkg::DATA_W-1:0] rsp_removed_value,
   input logic signed [spq_pkg::DATA_W-1:0] rsp_top_value,
   input logic signed [spq_pkg::DATA_W-1:0] rsp_top_priority,
   input logic [spq_pkg::TOTAL_W-1:0]       rsp_entry_total
);

   `SPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_removed_value) && $stable(rsp_top_value) && $stable(rsp_top_priority) && $stable(rsp_entry_total))
   `SPQ_ASSERT_NOW(a_total_bound, rsp_valid, rsp_entry_total <= spq_pkg::TOTAL_W'(spq_pkg::QUEUE_DEPTH))
   `SPQ_ASSERT_NOW(a_empty_top, rsp_valid && rsp_entry_total == '0, rsp_top_value == '0 && rsp_top_priority == '0)
   `SPQ_ASSERT_NOW(a_underflow, rsp_valid && rsp_status == spq_pkg::ST_EMPTY, rsp_entry_total == '0 && rsp_removed_value == '0)
   `SPQ_ASSERT_NOW(a_overflow, rsp_valid && rsp_status == spq_pkg::ST_FULL, rsp_entry_total == spq_pkg::TOTAL_W'(spq_pkg::QUEUE_DEPTH) && rsp_removed_value == '0)

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_removed_value (rsp_chan.removed_value),
   .rsp_top_value     (rsp_chan.top_value),
   .rsp_top_priority  (rsp_chan.top_priority),
   .rsp_entry_total   (rsp_chan.entry_total)
);
